>>> design/dsm_pkg.sv
// Shared types, field widths and codes for the diagonal sparse matrix-vector block.
`timescale 1ns / 1ps

package dsm_pkg;

    localparam int ROW_W      = 10;
    localparam int SLOT_W     = 4;
    localparam int OFF_W      = 11;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int NROWS_W    = 11;
    localparam int NDIAGS_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_W     = 16;

    // cycles from the last issued diagonal until its product sits in the accumulator
    localparam int DRAIN_CYC  = 3;
    localparam int DRAIN_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIAGS = 2'd1;

    localparam logic [NROWS_W-1:0]  NUM_ROWS_RST  = 11'd1024;
    localparam logic [NDIAGS_W-1:0] NUM_DIAGS_RST = 5'd0;

    typedef enum logic [1:0] {
        MODE_LOAD_OFFSET = 2'd0,
        MODE_LOAD_VALUE  = 2'd1,
        MODE_LOAD_X      = 2'd2,
        MODE_COMPUTE     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND,
        S_SAT
    } t_state;

    typedef struct packed {
        logic clr;
        logic rnd;
        logic fin;
    } t_mac_ctl;

endpackage

>>> design/dsm_store.sv
// Offset, value and x memories with the two-stage lookup of one diagonal term.
`timescale 1ns / 1ps

module dsm_store #(
    parameter int MAX_ROWS  = 1024,
    parameter int MAX_DIAGS = 16,
    localparam int DAW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1,
    localparam int XAW = $clog2(MAX_ROWS),
    localparam int VAW = (MAX_ROWS * MAX_DIAGS > 1) ? $clog2(MAX_ROWS * MAX_DIAGS) : 1,
    localparam int BW  = $clog2(MAX_ROWS + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we_off,
    input  logic                                   i_we_val,
    input  logic                                   i_we_x,
    input  logic [DAW-1:0]                         i_wr_slot,
    input  logic [XAW-1:0]                         i_wr_xaddr,
    input  logic [VAW-1:0]                         i_wr_vaddr,
    input  logic signed [dsm_pkg::OFF_W-1:0]       i_wr_offset,
    input  logic signed [dsm_pkg::DATA_W-1:0]      i_wr_data,
    input  logic                                   i_issue,
    input  logic [DAW-1:0]                         i_rd_slot,
    input  logic [VAW-1:0]                         i_rd_vaddr,
    input  logic [dsm_pkg::ROW_W-1:0]              i_row,
    input  logic [BW-1:0]                          i_bound,
    output logic                                   o_term_vld,
    output logic signed [dsm_pkg::DATA_W-1:0]      o_val,
    output logic signed [dsm_pkg::DATA_W-1:0]      o_x
);

    logic signed [dsm_pkg::OFF_W-1:0]  off_mem [MAX_DIAGS];
    logic signed [dsm_pkg::DATA_W-1:0] val_mem [MAX_ROWS * MAX_DIAGS];
    logic signed [dsm_pkg::DATA_W-1:0] x_mem   [MAX_ROWS];

    logic                              r_v1;
    logic signed [dsm_pkg::OFF_W-1:0]  r_off;
    logic signed [dsm_pkg::DATA_W-1:0] r_val;
    logic                              r_v2;
    logic signed [dsm_pkg::DATA_W-1:0] r_val2;
    logic signed [dsm_pkg::DATA_W-1:0] r_x;

    logic signed [dsm_pkg::OFF_W:0]    col;
    logic                              col_ok;
    logic [XAW-1:0]                    xaddr;

    always_ff @(posedge i_clk) begin
        if (i_we_off) begin
            off_mem[i_wr_slot] <= i_wr_offset;
        end
        if (i_we_val) begin
            val_mem[i_wr_vaddr] <= i_wr_data;
        end
        if (i_we_x) begin
            x_mem[i_wr_xaddr] <= i_wr_data;
        end
    end

    // stage 1: fetch offset and matrix value of the issued slot
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_off <= off_mem[i_rd_slot];
            r_val <= val_mem[i_rd_vaddr];
        end
    end

    // column = row + offset, kept only if inside 0 .. bound-1
    assign col    = $signed({2'b00, i_row}) + $signed({r_off[dsm_pkg::OFF_W-1], r_off});
    assign col_ok = !col[dsm_pkg::OFF_W]
                    && (32'(col[dsm_pkg::OFF_W-1:0]) < 32'(i_bound));
    assign xaddr  = XAW'(32'(col[dsm_pkg::OFF_W-1:0]));

    // stage 2: fetch x at that column
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_x    <= x_mem[xaddr];
            r_val2 <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1 && col_ok;
        end
    end

    assign o_term_vld = r_v2;
    assign o_val      = r_val2;
    assign o_x        = r_x;

endmodule

>>> design/dsm_mac.sv
// Shared multiply-accumulate unit with round-half-up and Q16.16 saturation.
`timescale 1ns / 1ps

module dsm_mac #(
    parameter int MAX_DIAGS = 16,
    localparam int AW = dsm_pkg::PROD_W + $clog2(MAX_DIAGS) + 1,
    localparam int RW = AW - dsm_pkg::FRAC_W
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dsm_pkg::t_mac_ctl                      i_ctl,
    input  logic                                   i_term_vld,
    input  logic signed [dsm_pkg::DATA_W-1:0]      i_val,
    input  logic signed [dsm_pkg::DATA_W-1:0]      i_x,
    input  logic [dsm_pkg::ROW_W-1:0]              i_row,
    output logic                                   o_valid,
    output logic [dsm_pkg::ROW_W-1:0]              o_out_row,
    output logic signed [dsm_pkg::DATA_W-1:0]      o_y_value,
    output logic                                   o_saturated
);

    logic                              r_v3;
    logic signed [dsm_pkg::PROD_W-1:0] r_prod;
    logic signed [AW-1:0]              r_acc;
    logic signed [RW-1:0]              r_rnd;
    logic                              r_valid;
    logic [dsm_pkg::ROW_W-1:0]         r_out_row;
    logic signed [dsm_pkg::DATA_W-1:0] r_y;
    logic                              r_sat;

    logic signed [AW-1:0]              n_acc;
    logic [AW-1:0]                     biased;
    logic                              ovf;
    logic signed [dsm_pkg::DATA_W-1:0] clipped;

    always_ff @(posedge i_clk) begin
        if (i_term_vld) begin
            r_prod <= $signed(i_val) * $signed(i_x);
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (r_v3) begin
            n_acc = r_acc + {{(AW - dsm_pkg::PROD_W){r_prod[dsm_pkg::PROD_W-1]}}, r_prod};
        end
    end

    // add half an LSB of Q16.16, then drop the fraction bits (floor)
    assign biased = r_acc + AW'(1 << (dsm_pkg::FRAC_W - 1));

    // clip when the bits above bit 31 are not all copies of the sign
    assign ovf     = !((&r_rnd[RW-1:dsm_pkg::DATA_W-1]) || !(|r_rnd[RW-1:dsm_pkg::DATA_W-1]));
    assign clipped = r_rnd[RW-1] ? {1'b1, {(dsm_pkg::DATA_W-1){1'b0}}}
                                 : {1'b0, {(dsm_pkg::DATA_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_ctl.rnd) begin
            r_rnd <= biased[AW-1:dsm_pkg::FRAC_W];
        end
        if (i_ctl.fin) begin
            r_out_row <= i_row;
            r_y       <= ovf ? clipped : r_rnd[dsm_pkg::DATA_W-1:0];
            r_sat     <= ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v3    <= i_term_vld;
            r_valid <= i_ctl.fin;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_row   = r_out_row;
    assign o_y_value   = r_y;
    assign o_saturated = r_sat;

endmodule

>>> design/dsm_ctrl.sv
// Sequencer: steps the diagonal slots of one row through the shared datapath.
`timescale 1ns / 1ps

module dsm_ctrl #(
    parameter int MAX_ROWS  = 1024,
    parameter int MAX_DIAGS = 16,
    localparam int DAW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1,
    localparam int DCW = $clog2(MAX_DIAGS + 1),
    localparam int VAW = (MAX_ROWS * MAX_DIAGS > 1) ? $clog2(MAX_ROWS * MAX_DIAGS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_mode,
    input  logic [dsm_pkg::ROW_W-1:0]   i_row,
    input  logic [DCW-1:0]              i_nd,
    output logic                        o_busy,
    output logic                        o_issue,
    output logic [DAW-1:0]              o_slot,
    output logic [VAW-1:0]              o_vaddr,
    output logic [dsm_pkg::ROW_W-1:0]   o_row,
    output dsm_pkg::t_mac_ctl           o_mac
);

    dsm_pkg::t_state              r_state;
    dsm_pkg::t_state              n_state;
    logic [DAW-1:0]               r_j;
    logic [DAW-1:0]               n_j;
    logic [DCW-1:0]               r_nd;
    logic [DCW-1:0]               n_nd;
    logic [dsm_pkg::DRAIN_W-1:0]  r_cnt;
    logic [dsm_pkg::DRAIN_W-1:0]  n_cnt;
    logic [dsm_pkg::ROW_W-1:0]    r_row;
    logic [dsm_pkg::ROW_W-1:0]    n_row;
    logic [VAW-1:0]               r_base;
    logic [VAW-1:0]               n_base;

    logic                         cmp_go;
    logic                         row_ok;
    logic [DCW-1:0]               nd_acc;
    logic                         last;

    assign cmp_go = i_start && (r_state == dsm_pkg::S_IDLE)
                    && (i_mode == dsm_pkg::MODE_COMPUTE);
    assign row_ok = 32'(i_row) < MAX_ROWS;
    // a row past the stores issues nothing and reports zero
    assign nd_acc = row_ok ? i_nd : '0;
    assign last   = (32'(r_j) + 32'd1) == 32'(r_nd);

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_nd    = r_nd;
        n_cnt   = '0;
        n_row   = r_row;
        n_base  = r_base;
        case (r_state)
            dsm_pkg::S_IDLE: begin
                if (cmp_go) begin
                    n_state = (nd_acc != '0) ? dsm_pkg::S_RUN : dsm_pkg::S_DRAIN;
                    n_j     = '0;
                    n_nd    = nd_acc;
                    n_row   = i_row;
                    n_base  = VAW'(32'(i_row) * MAX_DIAGS);
                end
            end
            dsm_pkg::S_RUN: begin
                n_j = r_j + 1'b1;
                if (last) begin
                    n_state = dsm_pkg::S_DRAIN;
                end
            end
            dsm_pkg::S_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == dsm_pkg::DRAIN_W'(dsm_pkg::DRAIN_CYC - 1)) begin
                    n_state = dsm_pkg::S_ROUND;
                end
            end
            dsm_pkg::S_ROUND: begin
                n_state = dsm_pkg::S_SAT;
            end
            dsm_pkg::S_SAT: begin
                n_state = dsm_pkg::S_IDLE;
            end
            default: begin
                n_state = dsm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy    = 1'b1;
        o_issue   = 1'b0;
        o_mac.clr = 1'b0;
        o_mac.rnd = 1'b0;
        o_mac.fin = 1'b0;
        case (r_state)
            dsm_pkg::S_IDLE: begin
                o_busy    = 1'b0;
                o_mac.clr = cmp_go;
            end
            dsm_pkg::S_RUN: begin
                o_issue = 1'b1;
            end
            dsm_pkg::S_ROUND: begin
                o_mac.rnd = 1'b1;
            end
            dsm_pkg::S_SAT: begin
                o_mac.fin = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsm_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_nd   <= n_nd;
        r_row  <= n_row;
        r_base <= n_base;
    end

    assign o_slot  = r_j;
    assign o_vaddr = r_base + VAW'(r_j);
    assign o_row   = r_row;

endmodule

>>> design/dia_sparse_matvec.sv
// Top level of the diagonal-format sparse matrix-vector multiplier.
//
//  channel   direction  handshake                    payload
//  request   in         start & !busy                i_mode i_row i_slot i_diag_offset i_data_value
//  result    out        o_valid (one cycle)          o_out_row o_y_value o_saturated
//  config    in         i_cfg_valid & o_cfg_ready    i_cfg_index i_cfg_data
//
// Load requests keep busy low. A compute request holds busy while min(num_diags, MAX_DIAGS)
// diagonals pass one per cycle through the single multiplier and accumulator, the last
// products drain through the memory and multiply pipeline, the sum is rounded and then
// clipped. o_valid rises in the same cycle that busy falls.
// Synchronous active-low reset clears the sequencer and the config registers; the
// memories hold no reset. Results cannot be stalled; o_cfg_ready is always high.
`timescale 1ns / 1ps

module dia_sparse_matvec #(
    parameter int MAX_ROWS  = 1024,
    parameter int MAX_DIAGS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             i_mode,
    input  logic [dsm_pkg::ROW_W-1:0]              i_row,
    input  logic [dsm_pkg::SLOT_W-1:0]             i_slot,
    input  logic signed [dsm_pkg::OFF_W-1:0]       i_diag_offset,
    input  logic signed [dsm_pkg::DATA_W-1:0]      i_data_value,
    output logic                                   o_valid,
    output logic [dsm_pkg::ROW_W-1:0]              o_out_row,
    output logic signed [dsm_pkg::DATA_W-1:0]      o_y_value,
    output logic                                   o_saturated,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int DAW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;
    localparam int DCW = $clog2(MAX_DIAGS + 1);
    localparam int XAW = $clog2(MAX_ROWS);
    localparam int VAW = (MAX_ROWS * MAX_DIAGS > 1) ? $clog2(MAX_ROWS * MAX_DIAGS) : 1;
    localparam int BW  = $clog2(MAX_ROWS + 1);

    logic [dsm_pkg::NROWS_W-1:0]  r_num_rows;
    logic [dsm_pkg::NDIAGS_W-1:0] r_num_diags;

    logic                         accept;
    logic                         row_ok;
    logic                         slot_ok;
    logic                         we_off;
    logic                         we_val;
    logic                         we_x;
    logic [BW-1:0]                bound;
    logic [DCW-1:0]               nd_eff;

    logic                         issue;
    logic [DAW-1:0]               rd_slot;
    logic [VAW-1:0]               rd_vaddr;
    logic [dsm_pkg::ROW_W-1:0]    cur_row;
    dsm_pkg::t_mac_ctl            mac_ctl;
    logic                         term_vld;
    logic signed [dsm_pkg::DATA_W-1:0] term_val;
    logic signed [dsm_pkg::DATA_W-1:0] term_x;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= dsm_pkg::NUM_ROWS_RST;
            r_num_diags <= dsm_pkg::NUM_DIAGS_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dsm_pkg::CFG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data[dsm_pkg::NROWS_W-1:0];
            end else if (i_cfg_index == dsm_pkg::CFG_NUM_DIAGS) begin
                r_num_diags <= i_cfg_data[dsm_pkg::NDIAGS_W-1:0];
            end
        end
    end

    // column bound and slot count, clipped to the store sizes
    assign bound  = (32'(r_num_rows) < MAX_ROWS) ? BW'(r_num_rows) : BW'(MAX_ROWS);
    assign nd_eff = (32'(r_num_diags) < MAX_DIAGS) ? DCW'(r_num_diags) : DCW'(MAX_DIAGS);

    assign accept  = start && !busy;
    assign row_ok  = 32'(i_row) < MAX_ROWS;
    assign slot_ok = 32'(i_slot) < MAX_DIAGS;
    // drop loads that point past the stores
    assign we_off  = accept && (i_mode == dsm_pkg::MODE_LOAD_OFFSET) && slot_ok;
    assign we_val  = accept && (i_mode == dsm_pkg::MODE_LOAD_VALUE) && row_ok && slot_ok;
    assign we_x    = accept && (i_mode == dsm_pkg::MODE_LOAD_X) && row_ok;

    dsm_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_DIAGS (MAX_DIAGS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_mode),
        .i_row   (i_row),
        .i_nd    (nd_eff),
        .o_busy  (busy),
        .o_issue (issue),
        .o_slot  (rd_slot),
        .o_vaddr (rd_vaddr),
        .o_row   (cur_row),
        .o_mac   (mac_ctl)
    );

    dsm_store #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_DIAGS (MAX_DIAGS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we_off    (we_off),
        .i_we_val    (we_val),
        .i_we_x      (we_x),
        .i_wr_slot   (DAW'(i_slot)),
        .i_wr_xaddr  (XAW'(i_row)),
        .i_wr_vaddr  (VAW'(32'(i_row) * MAX_DIAGS + 32'(i_slot))),
        .i_wr_offset (i_diag_offset),
        .i_wr_data   (i_data_value),
        .i_issue     (issue),
        .i_rd_slot   (rd_slot),
        .i_rd_vaddr  (rd_vaddr),
        .i_row       (cur_row),
        .i_bound     (bound),
        .o_term_vld  (term_vld),
        .o_val       (term_val),
        .o_x         (term_x)
    );

    dsm_mac #(
        .MAX_DIAGS (MAX_DIAGS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_term_vld  (term_vld),
        .i_val       (term_val),
        .i_x         (term_x),
        .i_row       (cur_row),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_y_value   (o_y_value),
        .o_saturated (o_saturated)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for the diagonal sparse matrix-vector block.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_DIAGS   = 16;
    localparam int ITEM_TARGET = 1100;
    localparam int CALM_ITEMS  = 150;
    localparam int SETTLE_CYC  = 24;   // covers the longest compute and its result
    localparam int TAIL_CYC    = 40;
    localparam int LIMIT_CYC   = 400000;

    localparam int ROW_W      = dsm_pkg::ROW_W;
    localparam int SLOT_W     = dsm_pkg::SLOT_W;
    localparam int OFF_W      = dsm_pkg::OFF_W;
    localparam int DATA_W     = dsm_pkg::DATA_W;
    localparam int FRAC_W     = dsm_pkg::FRAC_W;
    localparam int NROWS_W    = dsm_pkg::NROWS_W;
    localparam int NDIAGS_W   = dsm_pkg::NDIAGS_W;
    localparam int CFG_IDX_W  = dsm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dsm_pkg::CFG_DATA_W;

    // indexes the block decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {
        ENT_REQ,
        ENT_CFG
    } t_ent_kind;

    typedef struct {
        t_ent_kind                kind;
        dsm_pkg::t_mode           mode;
        logic [ROW_W-1:0]         row;
        logic [SLOT_W-1:0]        slot;
        logic signed [OFF_W-1:0]  offs;
        logic [DATA_W-1:0]        data;
        logic [CFG_IDX_W-1:0]     cidx;
        logic [CFG_DATA_W-1:0]    cdata;
        bit                       calm;
    } t_tb_entry;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic signed [DATA_W-1:0] y;
        logic                     sat;
    } t_y_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         req_start = 1'b0;
    logic                         busy;
    logic [1:0]                   drv_mode = '0;
    logic [ROW_W-1:0]             drv_row = '0;
    logic [SLOT_W-1:0]            drv_slot = '0;
    logic signed [OFF_W-1:0]      drv_offs = '0;
    logic signed [DATA_W-1:0]     drv_data = '0;
    logic                         o_valid;
    logic [ROW_W-1:0]             o_out_row;
    logic signed [DATA_W-1:0]     o_y_value;
    logic                         o_saturated;
    logic                         cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    dia_sparse_matvec u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (req_start),
        .busy          (busy),
        .i_mode        (drv_mode),
        .i_row         (drv_row),
        .i_slot        (drv_slot),
        .i_diag_offset (drv_offs),
        .i_data_value  (drv_data),
        .o_valid       (o_valid),
        .o_out_row     (o_out_row),
        .o_y_value     (o_y_value),
        .o_saturated   (o_saturated),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_tb_entry   req_backlog[$];
    t_y_result   y_due[$];
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    // predictor copy of the block's stores and registers
    logic signed [OFF_W-1:0]  offs_tab [MAX_DIAGS];
    logic signed [DATA_W-1:0] val_tab  [MAX_ROWS][MAX_DIAGS];
    logic signed [DATA_W-1:0] x_tab    [MAX_ROWS];
    logic [NROWS_W-1:0]       cur_rows = dsm_pkg::NUM_ROWS_RST;
    logic [NDIAGS_W-1:0]      cur_diags = dsm_pkg::NUM_DIAGS_RST;

    // generator shadow: which entries hold data, so no compute reads an unwritten one
    int                       g_offs   [MAX_DIAGS];
    bit                       g_offs_ok[MAX_DIAGS];
    bit [MAX_DIAGS-1:0]       g_val_ok [MAX_ROWS];
    bit                       g_x_ok   [MAX_ROWS];
    int                       g_rows = 1024;
    int                       g_diags = 0;
    int                       g_items = 0;
    bit                       g_wide = 1'b0;

    function automatic t_y_result row_dot(input logic [ROW_W-1:0] r);
        logic signed [71:0] acc;
        logic signed [71:0] q;
        logic signed [63:0] prod;
        int                 bound;
        int                 nd;
        int                 col;
        t_y_result          res;
        acc   = '0;
        bound = (cur_rows < NROWS_W'(MAX_ROWS)) ? int'(cur_rows) : MAX_ROWS;
        nd    = (cur_diags < NDIAGS_W'(MAX_DIAGS)) ? int'(cur_diags) : MAX_DIAGS;
        for (int j = 0; j < nd; j++) begin
            col = int'(r) + int'(offs_tab[j]);
            if (col >= 0 && col < bound) begin
                prod = val_tab[r][j] * x_tab[col];
                acc  = acc + prod;
            end
        end
        // round half up, then clip to Q16.16
        q       = (acc + 72'sd32768) >>> FRAC_W;
        res.row = r;
        res.sat = 1'b1;
        if (q > 72'sd2147483647)
            res.y = 32'sh7FFF_FFFF;
        else if (q < -72'sd2147483648)
            res.y = 32'sh8000_0000;
        else begin
            res.y   = q[DATA_W-1:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic signed [OFF_W-1:0] pick_offset();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return ($urandom_range(0, 1) != 0) ? 11'sh400 : 11'sh3FF;
        if (k <= 2)
            return OFF_W'($urandom);
        return OFF_W'($urandom_range(0, 24) - 12);
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0001_0000;
                default: return 32'h0000_8000;
            endcase
        end
        if (k <= 2 || (g_wide && k <= 5))
            return $urandom;
        // mostly values within +-16.0 so sums stay in range
        return DATA_W'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
    endfunction

    function automatic int pick_row(input int base);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, MAX_ROWS - 1);
            1:       return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(1020, 1023);
            default: return base + $urandom_range(0, 31);
        endcase
    endfunction

    task automatic push_req(input dsm_pkg::t_mode m, input int r, input int s,
                            input logic signed [OFF_W-1:0] o, input logic [DATA_W-1:0] d);
        t_tb_entry e;
        e.kind  = ENT_REQ;
        e.mode  = m;
        e.row   = ROW_W'(r);
        e.slot  = SLOT_W'(s);
        e.offs  = o;
        e.data  = d;
        e.cidx  = '0;
        e.cdata = '0;
        e.calm  = (g_items >= ITEM_TARGET - CALM_ITEMS);
        case (m)
            dsm_pkg::MODE_LOAD_OFFSET: begin
                g_offs[e.slot]    = int'(o);
                g_offs_ok[e.slot] = 1'b1;
            end
            dsm_pkg::MODE_LOAD_VALUE: g_val_ok[e.row][e.slot] = 1'b1;
            dsm_pkg::MODE_LOAD_X:     g_x_ok[e.row] = 1'b1;
            default: ;
        endcase
        req_backlog.push_back(e);
        g_items++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input int v);
        t_tb_entry e;
        e.kind  = ENT_CFG;
        e.mode  = dsm_pkg::MODE_LOAD_OFFSET;
        e.row   = '0;
        e.slot  = '0;
        e.offs  = '0;
        e.data  = '0;
        e.cidx  = idx;
        e.calm  = 1'b0;
        // upper bits are junk the block must drop
        e.cdata = CFG_DATA_W'($urandom);
        if (idx == dsm_pkg::CFG_NUM_ROWS) begin
            e.cdata[NROWS_W-1:0] = NROWS_W'(v);
            g_rows = v;
        end else if (idx == dsm_pkg::CFG_NUM_DIAGS) begin
            e.cdata[NDIAGS_W-1:0] = NDIAGS_W'(v);
            g_diags = v;
        end
        req_backlog.push_back(e);
    endtask

    task automatic load_off(input int s, input logic signed [OFF_W-1:0] o);
        push_req(dsm_pkg::MODE_LOAD_OFFSET, $urandom_range(0, MAX_ROWS - 1), s, o, $urandom);
    endtask

    task automatic load_val(input int r, input int s, input logic [DATA_W-1:0] d);
        push_req(dsm_pkg::MODE_LOAD_VALUE, r, s, OFF_W'($urandom), d);
    endtask

    task automatic load_x(input int r, input logic [DATA_W-1:0] d);
        push_req(dsm_pkg::MODE_LOAD_X, r, $urandom_range(0, MAX_DIAGS - 1),
                 OFF_W'($urandom), d);
    endtask

    // fill whatever the row will read, then request it
    task automatic compute_row(input int r);
        int nd;
        int bound;
        int col;
        nd    = (g_diags < MAX_DIAGS) ? g_diags : MAX_DIAGS;
        bound = (g_rows < MAX_ROWS) ? g_rows : MAX_ROWS;
        for (int j = 0; j < nd; j++) begin
            if (!g_offs_ok[j])
                load_off(j, pick_offset());
            col = r + g_offs[j];
            if (col >= 0 && col < bound) begin
                if (!g_val_ok[r][j])
                    load_val(r, j, pick_data());
                if (!g_x_ok[col])
                    load_x(col, pick_data());
            end
        end
        push_req(dsm_pkg::MODE_COMPUTE, r, $urandom_range(0, MAX_DIAGS - 1),
                 OFF_W'($urandom), $urandom);
    endtask

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        int ph_rows [7];
        int ph_diags[7];
        int base;
        int k;
        int r;
        int phase_end;
        ph_rows  = '{1024, 16, 1, 0, 2047, 1000, 33};
        ph_diags = '{16, 4, 31, 1, 16, 9, 0};

        // reset setting: no diagonals, so y is zero
        compute_row(0);
        push_cfg(dsm_pkg::CFG_NUM_DIAGS, 2);
        push_cfg(dsm_pkg::CFG_NUM_ROWS, 1024);
        load_off(0, 11'sd0);
        load_off(1, 11'sd1);
        // positive clip
        load_val(7, 0, 32'h7FFF_FFFF);
        load_val(7, 1, 32'h7FFF_FFFF);
        load_x(7, 32'h7FFF_FFFF);
        load_x(8, 32'h7FFF_FFFF);
        compute_row(7);
        // negative clip
        load_val(9, 0, 32'h8000_0000);
        load_val(9, 1, 32'h8000_0000);
        load_x(10, 32'h7FFF_FFFF);
        compute_row(9);
        // exact half rounds up, both signs
        load_val(11, 0, 32'h0000_0001);
        load_val(11, 1, 32'h0000_0000);
        load_x(11, 32'h0000_8000);
        compute_row(11);
        load_val(13, 0, 32'hFFFF_FFFF);
        load_val(13, 1, 32'h0000_0000);
        load_x(13, 32'h0000_8000);
        compute_row(13);
        // extreme offsets: last column reached, columns below zero and past the end skipped
        load_off(1, 11'sd1023);
        compute_row(0);
        load_off(0, 11'sh400);
        compute_row(1023);
        // zero rows drops every column; a bound past the store clamps to it
        push_cfg(dsm_pkg::CFG_NUM_ROWS, 0);
        compute_row(7);
        push_cfg(dsm_pkg::CFG_NUM_ROWS, 2047);
        compute_row(1023);

        for (int p = 0; g_items < ITEM_TARGET; p++) begin
            if (p < 7) begin
                push_cfg(dsm_pkg::CFG_NUM_ROWS, ph_rows[p]);
                push_cfg(dsm_pkg::CFG_NUM_DIAGS, ph_diags[p]);
            end else begin
                push_cfg(dsm_pkg::CFG_NUM_DIAGS, $urandom_range(0, 31));
                push_cfg(dsm_pkg::CFG_NUM_ROWS, $urandom_range(0, 2047));
            end
            if (p == 3)
                push_cfg(CFG_SPARE_2, $urandom);
            if (p == 5)
                push_cfg(CFG_SPARE_3, $urandom);
            g_wide    = p[0];
            base      = (g_rows < 64 && $urandom_range(0, 1) != 0) ? 0
                                                                  : $urandom_range(0, 992);
            phase_end = g_items + 110;
            while (g_items < phase_end && g_items < ITEM_TARGET) begin
                k = $urandom_range(0, 19);
                r = pick_row(base);
                if (k < 11)
                    compute_row(r);
                else if (k < 14)
                    load_off($urandom_range(0, MAX_DIAGS - 1), pick_offset());
                else if (k < 17)
                    load_val(r, $urandom_range(0, MAX_DIAGS - 1), pick_data());
                else
                    load_x(pick_row(base), pick_data());
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_start || cfg_valid)
            @(posedge i_clk);
        while (y_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYC) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driver

    t_tb_entry inflight;
    int        gap_left = 0;
    int        calm_left = 0;
    int        quiet_cyc = 0;

    always @(posedge i_clk) begin : driver
        logic nxt_start;
        logic nxt_cv;
        if (!i_rst_n) begin
            req_start <= 1'b0;
            cfg_valid <= 1'b0;
            cur_rows  = dsm_pkg::NUM_ROWS_RST;
            cur_diags = dsm_pkg::NUM_DIAGS_RST;
            quiet_cyc = 0;
        end else begin
            nxt_start = req_start;
            nxt_cv    = cfg_valid;
            if (!req_start && !cfg_valid && !busy && o_valid !== 1'b1)
                quiet_cyc = (quiet_cyc < 1000) ? quiet_cyc + 1 : quiet_cyc;
            else
                quiet_cyc = 0;

            if (req_start && !busy) begin
                case (inflight.mode)
                    dsm_pkg::MODE_LOAD_OFFSET: begin
                        offs_tab[inflight.slot] = inflight.offs;
                    end
                    dsm_pkg::MODE_LOAD_VALUE: begin
                        val_tab[inflight.row][inflight.slot] = inflight.data;
                    end
                    dsm_pkg::MODE_LOAD_X: begin
                        x_tab[inflight.row] = inflight.data;
                    end
                    default: y_due.push_back(row_dot(inflight.row));
                endcase
                nxt_start = 1'b0;
            end
            if (cfg_valid && o_cfg_ready) begin
                if (inflight.cidx == dsm_pkg::CFG_NUM_ROWS)
                    cur_rows = inflight.cdata[NROWS_W-1:0];
                else if (inflight.cidx == dsm_pkg::CFG_NUM_DIAGS)
                    cur_diags = inflight.cdata[NDIAGS_W-1:0];
                nxt_cv = 1'b0;
            end

            if (!nxt_start && !nxt_cv) begin
                if (gap_left > 0)
                    gap_left--;
                else if (req_backlog.size() != 0) begin
                    if (req_backlog[0].kind == ENT_CFG) begin
                        // hold config until the block has drained
                        if (quiet_cyc >= SETTLE_CYC && y_due.size() == 0) begin
                            inflight = req_backlog.pop_front();
                            cfg_index <= inflight.cidx;
                            cfg_data  <= inflight.cdata;
                            nxt_cv = 1'b1;
                        end
                    end else begin
                        inflight = req_backlog.pop_front();
                        drv_mode <= inflight.mode;
                        drv_row  <= inflight.row;
                        drv_slot <= inflight.slot;
                        drv_offs <= inflight.offs;
                        drv_data <= inflight.data;
                        nxt_start = 1'b1;
                        // idle burst after this request, or a stretch with none
                        if (inflight.calm)
                            gap_left = 0;
                        else if (calm_left > 0)
                            calm_left--;
                        else begin
                            case ($urandom_range(0, 19))
                                0:             calm_left = $urandom_range(20, 60);
                                1, 2, 3, 4, 5: gap_left = $urandom_range(1, 13);
                                default: ;
                            endcase
                        end
                    end
                end
            end
            req_start <= nxt_start;
            cfg_valid <= nxt_cv;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : monitor
        t_y_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (y_due.size() == 0)
                flag_mismatch($sformatf("result for row %0d with no compute request open",
                                        o_out_row));
            else begin
                want = y_due.pop_front();
                if (o_out_row !== want.row)
                    flag_mismatch($sformatf("out_row %0d, expected %0d", o_out_row, want.row));
                if (o_y_value !== want.y)
                    flag_mismatch($sformatf("row %0d: y_value %h, expected %h",
                                            want.row, o_y_value, want.y));
                if (o_saturated !== want.sat)
                    flag_mismatch($sformatf("row %0d: saturated %b, expected %b",
                                            want.row, o_saturated, want.sat));
            end
        end
    end

endmodule
